// ===== rtl/sgss_pkg.sv =====
// Shared constants, sigmoid table and pipeline control type for the gated state scan.
package sgss_pkg;

	localparam int DEF_STATE_CHANNELS = 16;
	localparam int DEF_VALUE_WIDTH    = 16;
	localparam int CHANNEL_W          = 4;
	localparam int CHANNEL_COUNT      = 16;
	localparam int ALPHA_W            = 16;
	// widest step between neighboring table entries (8025) fits here
	localparam int DELTA_W            = 13;
	localparam int IDX_W              = 5;
	localparam int SIG_LAST           = 16;

	// round(65536 * sigmoid(k/2)), k = 0..16
	localparam logic [ALPHA_W-1:0] SIG_HALF_STEPS [0:SIG_LAST] = '{
		16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
		16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
		16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
	};

	// load enables of pipeline stages s2 to s5
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

endpackage

// ===== rtl/sgss_sigmoid.sv =====
// Three-stage sigmoid: table lookup, interpolation multiply, rounding and sign fold.
module sgss_sigmoid #(
	parameter int VALUE_WIDTH = sgss_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic [VALUE_WIDTH-1:0]        gate_s1,
	input  sgss_pkg::pipe_en_t            en,
	output logic [sgss_pkg::ALPHA_W-1:0]  alpha_s4
);

	localparam int SS = VALUE_WIDTH - 5;
	localparam int PW = sgss_pkg::DELTA_W + SS;
	localparam logic [PW-1:0] ROUND_HALF = {{(PW-1){1'b0}}, 1'b1} << (SS - 1);
	localparam logic [sgss_pkg::ALPHA_W:0] ONE_Q16 = {1'b1, {sgss_pkg::ALPHA_W{1'b0}}};

	logic                          neg;
	logic [VALUE_WIDTH-1:0]        mag;
	logic [sgss_pkg::IDX_W-1:0]    idx;
	logic [sgss_pkg::IDX_W-1:0]    hi_idx;
	logic [sgss_pkg::ALPHA_W-1:0]  lo;
	logic [sgss_pkg::DELTA_W-1:0]  delta;

	logic                          neg_s2;
	logic [sgss_pkg::ALPHA_W-1:0]  lo_s2;
	logic [sgss_pkg::DELTA_W-1:0]  delta_s2;
	logic [SS-1:0]                 frac_s2;

	logic                          neg_s3;
	logic [sgss_pkg::ALPHA_W-1:0]  lo_s3;
	logic [PW-1:0]                 prod_s3;

	logic [PW-1:0]                 rsum;
	logic [sgss_pkg::DELTA_W-1:0]  step;
	logic [sgss_pkg::ALPHA_W:0]    sig;
	logic [sgss_pkg::ALPHA_W:0]    alpha;

	always_comb begin
		neg = gate_s1[VALUE_WIDTH-1];
		// the most negative gate gives 2^(VALUE_WIDTH-1), still exact as unsigned
		mag = neg ? VALUE_WIDTH'(~gate_s1 + VALUE_WIDTH'(1)) : gate_s1;
		idx = mag[VALUE_WIDTH-1:SS];
		// only |g| = 8 reaches the last entry; it has no slope
		hi_idx = idx[sgss_pkg::IDX_W-1] ? idx : idx + sgss_pkg::IDX_W'(1);
		lo = sgss_pkg::SIG_HALF_STEPS[idx];
		delta = sgss_pkg::DELTA_W'(sgss_pkg::SIG_HALF_STEPS[hi_idx] - lo);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			neg_s2   <= neg;
			lo_s2    <= lo;
			delta_s2 <= delta;
			frac_s2  <= mag[SS-1:0];
		end
		if (en.s3) begin
			neg_s3  <= neg_s2;
			lo_s3   <= lo_s2;
			prod_s3 <= PW'(delta_s2) * PW'(frac_s2);
		end
		if (en.s4) begin
			alpha_s4 <= alpha[sgss_pkg::ALPHA_W-1:0];
		end
	end

	always_comb begin
		rsum  = prod_s3 + ROUND_HALF;
		step  = sgss_pkg::DELTA_W'(rsum >> SS);
		sig   = (sgss_pkg::ALPHA_W+1)'(lo_s3) + (sgss_pkg::ALPHA_W+1)'(step);
		alpha = neg_s3 ? ONE_Q16 - sig : sig;
	end

endmodule

// ===== rtl/sgss_update.sv =====
// Per-channel state store and the stage that reads, mixes and writes back the state in the same cycle.
module sgss_update #(
	parameter int STATE_CHANNELS = sgss_pkg::DEF_STATE_CHANNELS,
	parameter int VALUE_WIDTH    = sgss_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sgss_pkg::pipe_en_t                  en,
	input  logic                                valid_s4,
	input  logic [sgss_pkg::CHANNEL_W-1:0]      channel_s4,
	input  logic signed [VALUE_WIDTH-1:0]       q_s4,
	input  logic                                first_s4,
	input  logic [sgss_pkg::ALPHA_W-1:0]        alpha_s4,
	output logic [sgss_pkg::CHANNEL_W-1:0]      channel_s5,
	output logic signed [VALUE_WIDTH-1:0]       state_s5,
	output logic [sgss_pkg::ALPHA_W-1:0]        alpha_s5
);

	// the 4-bit channel never reaches more than sixteen slots
	localparam int DEPTH = (STATE_CHANNELS < sgss_pkg::CHANNEL_COUNT) ?
		STATE_CHANNELS : sgss_pkg::CHANNEL_COUNT;
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [VALUE_WIDTH-1:0] MAX_V = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] MIN_V = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic signed [VALUE_WIDTH-1:0]  state_q [DEPTH];
	logic [SLOT_W-1:0]              slot;
	logic signed [VALUE_WIDTH-1:0]  prev;
	logic signed [VALUE_WIDTH:0]    diff;
	logic signed [VALUE_WIDTH+17:0] prod;
	logic signed [VALUE_WIDTH+17:0] rsum;
	logic signed [VALUE_WIDTH+1:0]  mix;
	logic signed [VALUE_WIDTH+1:0]  nsum;
	logic signed [VALUE_WIDTH-1:0]  nstate;

	always_comb begin
		slot = '0;
		for (int k = 0; k < sgss_pkg::CHANNEL_COUNT; k++) begin
			if (channel_s4 == sgss_pkg::CHANNEL_W'(k)) begin
				slot = SLOT_W'(k % DEPTH);
			end
		end
	end

	// alpha*prev + (1-alpha)*q = q + alpha*(prev - q), rounded half up
	always_comb begin
		prev = first_s4 ? '0 : state_q[slot];
		diff = $signed({prev[VALUE_WIDTH-1], prev}) - $signed({q_s4[VALUE_WIDTH-1], q_s4});
		prod = diff * $signed({1'b0, alpha_s4});
		rsum = prod + (VALUE_WIDTH+18)'(32768);
		mix  = rsum[VALUE_WIDTH+17:16];
		nsum = mix + $signed({{2{q_s4[VALUE_WIDTH-1]}}, q_s4});
		if (nsum[VALUE_WIDTH+1:VALUE_WIDTH-1] == 3'b000 ||
		    nsum[VALUE_WIDTH+1:VALUE_WIDTH-1] == 3'b111) begin
			nstate = nsum[VALUE_WIDTH-1:0];
		end else begin
			nstate = nsum[VALUE_WIDTH+1] ? MIN_V : MAX_V;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				state_q[k] <= '0;
			end
		end else if (valid_s4 && en.s5) begin
			state_q[slot] <= nstate;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			channel_s5 <= channel_s4;
			state_s5   <= nstate;
			alpha_s5   <= alpha_s4;
		end
	end

endmodule

// ===== rtl/sigmoid_gated_state_scan.sv =====
// Top level of the sigmoid-gated state scan: input stage, stall chain and output stage.
//
// Takes one item per clock while item_stall is low and returns one result per item, in
// order, through the stage registers s1 to s5. Three stages form alpha = sigmoid(gate)
// (table lookup, interpolation multiply, rounding); the fourth reads the channel's state,
// mixes it with q by one multiply and add, and writes it back in the same cycle, so items
// of the same channel may follow each other on consecutive cycles. That read-mix-write
// loop sets the clock. A stall on the result side holds the whole pipeline; bubbles
// close up, so input stall rises only when every stage holds an item.
module sigmoid_gated_state_scan #(
	parameter int STATE_CHANNELS = sgss_pkg::DEF_STATE_CHANNELS,
	parameter int VALUE_WIDTH    = sgss_pkg::DEF_VALUE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [sgss_pkg::CHANNEL_W-1:0]     channel,
	input  logic signed [VALUE_WIDTH-1:0]      q_value,
	input  logic signed [VALUE_WIDTH-1:0]      gate_value,
	input  logic                               first_step,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [sgss_pkg::CHANNEL_W-1:0]     channel_out,
	output logic signed [VALUE_WIDTH-1:0]      state_value,
	output logic [sgss_pkg::ALPHA_W-1:0]       alpha_value
);

	sgss_pkg::pipe_en_t en;
	logic en_s1;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [sgss_pkg::CHANNEL_W-1:0] channel_s1, channel_s2, channel_s3, channel_s4;
	logic signed [VALUE_WIDTH-1:0]  q_s1, q_s2, q_s3, q_s4;
	logic [VALUE_WIDTH-1:0]         gate_s1;
	logic                           first_s1, first_s2, first_s3, first_s4;
	logic [sgss_pkg::ALPHA_W-1:0]   alpha_s4;

	// a stage loads when it is empty or its item moves on
	always_comb begin
		en.s5 = !valid_s5 || !result_stall;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en_s1 = !valid_s1 || en.s2;
	end

	assign item_stall   = !en_s1;
	assign result_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= item_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			channel_s1 <= channel;
			q_s1       <= q_value;
			gate_s1    <= gate_value;
			first_s1   <= first_step;
		end
		if (en.s2) begin
			channel_s2 <= channel_s1;
			q_s2       <= q_s1;
			first_s2   <= first_s1;
		end
		if (en.s3) begin
			channel_s3 <= channel_s2;
			q_s3       <= q_s2;
			first_s3   <= first_s2;
		end
		if (en.s4) begin
			channel_s4 <= channel_s3;
			q_s4       <= q_s3;
			first_s4   <= first_s3;
		end
	end

	sgss_sigmoid #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_sigmoid (
		.clk      (clk),
		.gate_s1  (gate_s1),
		.en       (en),
		.alpha_s4 (alpha_s4)
	);

	sgss_update #(
		.STATE_CHANNELS (STATE_CHANNELS),
		.VALUE_WIDTH    (VALUE_WIDTH)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_s4   (valid_s4),
		.channel_s4 (channel_s4),
		.q_s4       (q_s4),
		.first_s4   (first_s4),
		.alpha_s4   (alpha_s4),
		.channel_s5 (channel_out),
		.state_s5   (state_value),
		.alpha_s5   (alpha_value)
	);

endmodule
